@@ src/rcf_pkg.sv @@
package rcf_pkg;

   localparam int SUM_W     = 14;
   localparam int CHAN_W    = 10;
   localparam int FRAME_LEN = 14;
   localparam int LEFT_W    = $clog2(FRAME_LEN);

   localparam logic [CHAN_W-1:0] CHAN_MAX = 10'h3ff;

   typedef enum logic [1:0] {
      TX_NORMAL = 2'd0,
      TX_BIND   = 2'd1,
      TX_SLAVE  = 2'd2,
      TX_MASTER = 2'd3
   } tx_mode_type;

   // frame byte codes
   localparam logic [7:0] HDR_NORMAL   = 8'h18;
   localparam logic [7:0] HDR_RANGE    = 8'h38;
   localparam logic [7:0] SLOT_AUX_ON  = 8'h10;
   localparam logic [7:0] SLOT_AUX_OFF = 8'h13;
   localparam logic [7:0] SLOT_BND_REL = 8'h14;
   localparam logic [7:0] SLOT_BND_PRS = 8'h17;
   localparam logic [7:0] PAT_HI       = 8'haa;
   localparam logic [7:0] PAT_LO       = 8'h54;

   // byte 0 in the lowest lane
   typedef logic [FRAME_LEN-1:0][7:0] frame_type;

   localparam frame_type BIND_FRAME = {
      8'haa, 8'h14, 8'haa, 8'h10, 8'hff, 8'h0d, 8'hff,
      8'h09, 8'hff, 8'h05, 8'h00, 8'h00, 8'h00, 8'h98
   };

   typedef struct packed {
      logic       bind_mode;
      logic       range_check;
      logic       unplugged;
      logic       trainer_breathe;
      logic       mix_on;
      logic [4:0] pulse_step;
   } fader_ctl_type;

   typedef struct packed {
      logic [6:0] power;
      logic [7:0] mode;
      logic [7:0] trainer;
      logic [7:0] mix;
   } duties_type;

endpackage

@@ src/rc_channel_frame_and_led_fader.sv @@
// RC channel frame encoder with LED fader. Each req_ transfer is one frame
// tick: four oversampled stick sums, the transmit mode, the range-check flag,
// panel and reverse switches and the power LED breathing step. A tick in
// normal mode, or trainer master with the rate switch high, yields a 14-byte
// channel frame (header, four 10-bit channels tagged by number, aux and bind
// slots); bind mode yields the fixed bind frame; slave control yields one
// status transfer with tuser low. rsp_tlast marks the final transfer of each
// tick, and every transfer of a tick carries the LED duties after that tick.
// A req_ transfer waits in the input register until the frame register is free
// and then loads into it; the frame register sends one rsp_ transfer per cycle
// while rsp_tready is high, and a tick holds the output for all its transfers.
// The output shifter's single byte lane limits the rate. The input register
// takes the next tick while the current frame drains, and the frame register
// reloads in the cycle its last byte is taken, so frames leave back to back.
module rc_channel_frame_and_led_fader import rcf_pkg::*; #(
   parameter int OVERSAMPLE_COUNT = 10   // samples per stick sum, 1..16
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   // [13:0] throttle_sum, [27:14] aileron_sum, [41:28] elevator_sum,
   // [55:42] rudder_sum, [60:56] panel_bits, [64:61] reverse_bits,
   // [69:65] pulse_step, [71:70] zero
   input  logic [71:0] req_tdata,
   // [1:0] tx_mode, [2] range_check
   input  logic [2:0]  req_tuser,
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] frame_byte, [14:8] power_duty, [22:15] mode_duty,
   // [30:23] trainer_duty, [38:31] mix_duty, [39] zero
   output logic [39:0] rsp_tdata,
   output logic        rsp_tuser,   // [0] byte_valid
   output logic        rsp_tlast    // last
);

   // Averaging by reciprocal multiply, exact for every 14-bit sum:
   // q = (sum * ceil(2^(14+l)/N)) >> (14+l), l = ceil(log2 N).
   localparam int     AVG_SHIFT = SUM_W + $clog2(OVERSAMPLE_COUNT);
   localparam longint RECIP     = ((longint'(1) << AVG_SHIFT) + longint'(OVERSAMPLE_COUNT) - 1)
                                  / longint'(OVERSAMPLE_COUNT);
   localparam int     RECIP_W   = $clog2(RECIP + 1);
   localparam int     PROD_W    = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP);

   function automatic logic [CHAN_W-1:0] stick_avg(input logic [SUM_W-1:0] sum);
      logic [PROD_W-1:0] prod;
      logic [PROD_W-1:0] quot;
      prod = PROD_W'(sum) * PROD_W'(RECIP_K);
      quot = prod >> AVG_SHIFT;
      return (quot > PROD_W'(CHAN_MAX)) ? CHAN_MAX : quot[CHAN_W-1:0];
   endfunction

   function automatic logic [7:0] chan_hi(input logic [1:0] tag, input logic [CHAN_W-1:0] v);
      return {4'b0000, tag, v[9:8]};
   endfunction

   // ---------------- input register ----------------
   logic              in_valid_ff;
   logic [SUM_W-1:0]  thr_sum_ff, ail_sum_ff, ele_sum_ff, rud_sum_ff;
   tx_mode_type       tx_mode_ff;
   logic              range_ff;
   logic [4:0]        panel_ff;
   logic [3:0]        rev_ff;
   logic [4:0]        step_ff;

   // ---------------- frame register ----------------
   logic              frame_valid_ff;
   frame_type         frame_ff, frame_in;
   logic [LEFT_W-1:0] left_ff, left_in;    // transfers still to follow
   logic              byte_valid_ff, byte_valid_in;
   duties_type        duty_ff, next_duty;

   logic              rsp_xfer, rsp_done, frame_load;
   fader_ctl_type     fader_ctl;

   assign rsp_xfer   = rsp_tvalid & rsp_tready;
   assign rsp_done   = rsp_xfer & rsp_tlast;
   assign frame_load = in_valid_ff & (~frame_valid_ff | rsp_done);
   assign req_tready = ~in_valid_ff | frame_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid & req_tready) begin
         thr_sum_ff <= req_tdata[13:0];
         ail_sum_ff <= req_tdata[27:14];
         ele_sum_ff <= req_tdata[41:28];
         rud_sum_ff <= req_tdata[55:42];
         panel_ff   <= req_tdata[60:56];
         rev_ff     <= req_tdata[64:61];
         step_ff    <= req_tdata[69:65];
         tx_mode_ff <= tx_mode_type'(req_tuser[1:0]);
         range_ff   <= req_tuser[2];
      end
   end

   // panel switches
   logic rate_hi, aux_on, bind_rel, mix_on, unplugged;
   assign rate_hi   = panel_ff[0];
   assign aux_on    = panel_ff[1];
   assign bind_rel  = panel_ff[2];
   assign mix_on    = panel_ff[3];
   assign unplugged = panel_ff[4];

   // ---------------- frame build ----------------
   logic [CHAN_W-1:0] thr, ail, ele, rud;
   logic              master_ctl;

   always_comb begin
      thr = stick_avg(thr_sum_ff);
      ail = CHAN_MAX - stick_avg(ail_sum_ff);
      ele = stick_avg(ele_sum_ff);
      rud = CHAN_MAX - stick_avg(rud_sum_ff);
      master_ctl = (tx_mode_ff == TX_NORMAL) | ((tx_mode_ff == TX_MASTER) & rate_hi);

      frame_in      = '0;
      left_in       = '0;
      byte_valid_in = 1'b0;
      if (master_ctl) begin
         frame_in[0]  = range_ff ? HDR_RANGE : HDR_NORMAL;
         frame_in[1]  = 8'h00;
         frame_in[2]  = chan_hi(2'd0, thr);
         frame_in[3]  = thr[7:0];
         frame_in[4]  = chan_hi(2'd1, ail);
         frame_in[5]  = ail[7:0];
         frame_in[6]  = chan_hi(2'd2, ele);
         frame_in[7]  = ele[7:0];
         frame_in[8]  = chan_hi(2'd3, rud);
         frame_in[9]  = rud[7:0];
         frame_in[10] = aux_on ? SLOT_AUX_ON : SLOT_AUX_OFF;
         frame_in[12] = bind_rel ? SLOT_BND_REL : SLOT_BND_PRS;
         if (mix_on) begin
            frame_in[11] = {3'b000, rate_hi, 4'b0000};
            frame_in[13] = {rev_ff, 4'b0000};
         end else begin
            frame_in[11] = aux_on ? PAT_HI : PAT_LO;
            frame_in[13] = bind_rel ? PAT_HI : PAT_LO;
         end
         left_in       = LEFT_W'(FRAME_LEN - 1);
         byte_valid_in = 1'b1;
      end else if (tx_mode_ff == TX_BIND) begin
         frame_in      = BIND_FRAME;
         left_in       = LEFT_W'(FRAME_LEN - 1);
         byte_valid_in = 1'b1;
      end
      // otherwise slave control: one status transfer, byte 0 and tuser low
   end

   // ---------------- LED faders ----------------
   assign fader_ctl.bind_mode       = (tx_mode_ff == TX_BIND);
   assign fader_ctl.range_check     = range_ff;
   assign fader_ctl.unplugged       = unplugged;
   assign fader_ctl.trainer_breathe = (tx_mode_ff == TX_MASTER) & ~rate_hi;
   assign fader_ctl.mix_on          = mix_on;
   assign fader_ctl.pulse_step      = step_ff;

   rcf_led_fader u_fader (
      .clock     (clock),
      .reset     (reset),
      .advance   (frame_load),
      .ctl       (fader_ctl),
      .next_duty (next_duty)
   );

   // ---------------- output shifter ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_valid_ff <= 1'b0;
      end else if (frame_load) begin
         frame_valid_ff <= 1'b1;
      end else if (rsp_done) begin
         frame_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_load) begin
         frame_ff      <= frame_in;
         left_ff       <= left_in;
         byte_valid_ff <= byte_valid_in;
         duty_ff       <= next_duty;
      end else if (rsp_xfer) begin
         frame_ff <= {8'h00, frame_ff[FRAME_LEN-1:1]};
         left_ff  <= left_ff - LEFT_W'(1);
      end
   end

   assign rsp_tvalid = frame_valid_ff;
   assign rsp_tlast  = (left_ff == '0);
   assign rsp_tuser  = byte_valid_ff;
   assign rsp_tdata  = {1'b0, duty_ff.mix, duty_ff.trainer, duty_ff.mode, duty_ff.power,
                        frame_ff[0]};

   // ---------------- assertions ----------------
   // a loaded tick is presented in the next cycle
   assert property (@(posedge clock) disable iff (reset) frame_load |=> rsp_tvalid)
      else $error("frame load not presented");

   // a status item stands alone
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_tvalid && !rsp_tuser) |-> rsp_tlast)
      else $error("status item not last");

   // a frame continues without a gap until its last byte
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_xfer && !rsp_tlast) |=> (rsp_tvalid && rsp_tuser))
      else $error("frame broken before last byte");

   // the mode and mix levels never pass their limit of 200
   assert property (@(posedge clock) disable iff (reset)
                    rsp_tvalid |-> (duty_ff.mode <= 8'd200 && duty_ff.mix <= 8'd200))
      else $error("LED duty out of range");

endmodule

@@ src/rcf_led_fader.sv @@
module rcf_led_fader import rcf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,    // one tick leaves the input stage
   input  fader_ctl_type ctl,
   output duties_type    next_duty   // levels after this tick
);

   localparam logic [7:0] LED_STEP  = 8'd10;
   localparam logic [7:0] LED_PEAK  = 8'd100;
   localparam logic [7:0] RISE_MAX  = 8'd190;
   localparam logic [7:0] POWER_CAP = 8'd127;
   localparam logic [7:0] FULL_CAP  = 8'd255;

   typedef struct packed {
      logic [7:0] level;
      logic       rising;
   } breath_type;

   function automatic breath_type breathe(input logic [7:0] level, input logic rising,
                                          input logic [7:0] step, input logic [7:0] cap);
      breath_type r;
      logic [8:0] sum;
      r.level  = level;
      r.rising = rising;
      sum      = {1'b0, level} + {1'b0, step};
      if (rising) begin
         if (level > LED_PEAK) begin
            r.rising = 1'b0;
         end else if (sum > {1'b0, cap}) begin
            r.level = cap;
         end else begin
            r.level = sum[7:0];
         end
      end else begin
         if (level < step) begin
            r.rising = 1'b1;
         end else begin
            r.level = level - step;
         end
      end
      return r;
   endfunction

   function automatic logic [7:0] rise_level(input logic [7:0] level);
      return (level <= RISE_MAX) ? level + LED_STEP : level;
   endfunction

   function automatic logic [7:0] fall_level(input logic [7:0] level);
      return (level >= LED_STEP) ? level - LED_STEP : level;
   endfunction

   logic [6:0] power_level_ff, power_level_in;
   logic [7:0] mode_level_ff, mode_level_in;
   logic [7:0] trainer_level_ff, trainer_level_in;
   logic [7:0] mix_level_ff, mix_level_in;
   logic       power_rising_ff, power_rising_in;
   logic       mode_rising_ff, mode_rising_in;
   logic       trainer_rising_ff, trainer_rising_in;

   breath_type power_b, mode_b, trainer_b;

   always_comb begin
      power_b   = breathe({1'b0, power_level_ff}, power_rising_ff,
                          {3'b000, ctl.pulse_step}, POWER_CAP);
      mode_b    = breathe(mode_level_ff, mode_rising_ff, LED_STEP, FULL_CAP);
      trainer_b = breathe(trainer_level_ff, trainer_rising_ff, LED_STEP, FULL_CAP);

      power_level_in  = power_b.level[6:0];
      power_rising_in = power_b.rising;

      priority if (ctl.bind_mode) begin
         mode_level_in  = mode_b.level;
         mode_rising_in = mode_b.rising;
      end else if (ctl.range_check) begin
         mode_level_in  = rise_level(mode_level_ff);
         mode_rising_in = 1'b1;
      end else begin
         mode_level_in  = fall_level(mode_level_ff);
         mode_rising_in = 1'b0;
      end

      priority if (ctl.unplugged) begin
         trainer_level_in  = fall_level(trainer_level_ff);
         trainer_rising_in = 1'b0;
      end else if (ctl.trainer_breathe) begin
         trainer_level_in  = trainer_b.level;
         trainer_rising_in = trainer_b.rising;
      end else begin
         trainer_level_in  = rise_level(trainer_level_ff);
         trainer_rising_in = 1'b1;
      end

      mix_level_in = ctl.mix_on ? rise_level(mix_level_ff) : fall_level(mix_level_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         power_level_ff    <= '0;
         mode_level_ff     <= '0;
         trainer_level_ff  <= '0;
         mix_level_ff      <= '0;
         power_rising_ff   <= 1'b1;
         mode_rising_ff    <= 1'b0;
         trainer_rising_ff <= 1'b0;
      end else if (advance) begin
         power_level_ff    <= power_level_in;
         mode_level_ff     <= mode_level_in;
         trainer_level_ff  <= trainer_level_in;
         mix_level_ff      <= mix_level_in;
         power_rising_ff   <= power_rising_in;
         mode_rising_ff    <= mode_rising_in;
         trainer_rising_ff <= trainer_rising_in;
      end
   end

   assign next_duty.power   = power_level_in;
   assign next_duty.mode    = mode_level_in;
   assign next_duty.trainer = trainer_level_in;
   assign next_duty.mix     = mix_level_in;

endmodule
